/* hdl/krt_pkg.sv */
// ----------------------------------------------------------------------------
// krt_pkg
// Shared types and constants for the keyed record table.
// ----------------------------------------------------------------------------
package krt_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int KEY_BITS_DEF   = 16;
    localparam int KEY_PORT_W     = 16;
    localparam int PAYLOAD_W      = 64;

    typedef enum logic [1:0] {
        FN_ADD = 2'd0,
        FN_GET = 2'd1,
        FN_DEL = 2'd2,
        FN_MOD = 2'd3
    } krt_func_t;

    typedef enum logic [1:0] {
        STS_DONE = 2'd0,
        STS_MISS = 2'd1,
        STS_FULL = 2'd2
    } krt_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_EXEC
    } krt_state_t;

    // per-cell control, driven by the sequencer
    typedef struct packed {
        logic cmp_en;       // capture match flag this cycle
        logic live;         // cell holds a valid record
        logic load_new;     // append the incoming record here
        logic shift;        // take the record of the next cell up
        logic load_payload; // overwrite payload only
    } krt_cell_ctl_t;

endpackage

/* hdl/krt_cell.sv */
// ----------------------------------------------------------------------------
// krt_cell
// One table slot: holds a key and payload, compares against the broadcast
// key, and can load from the next slot to close a gap after a delete.
// ----------------------------------------------------------------------------
module krt_cell #(
    parameter int KW = krt_pkg::KEY_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  krt_pkg::krt_cell_ctl_t        ctl,
    input  logic [KW-1:0]                 key_in,
    input  logic [krt_pkg::PAYLOAD_W-1:0] payload_in,
    input  logic [KW-1:0]                 nbr_key,
    input  logic [krt_pkg::PAYLOAD_W-1:0] nbr_payload,
    output logic [KW-1:0]                 key_out,
    output logic [krt_pkg::PAYLOAD_W-1:0] payload_out,
    output logic                          match
);

    logic [KW-1:0]                 key_reg;
    logic [KW-1:0]                 key_next;
    logic [krt_pkg::PAYLOAD_W-1:0] payload_reg;
    logic [krt_pkg::PAYLOAD_W-1:0] payload_next;
    logic                          match_reg;
    logic                          match_next;

    always_comb
    begin
        key_next     = key_reg;
        payload_next = payload_reg;
        if (ctl.load_new)
        begin
            key_next     = key_in;
            payload_next = payload_in;
        end
        else if (ctl.shift)
        begin
            key_next     = nbr_key;
            payload_next = nbr_payload;
        end
        else if (ctl.load_payload)
        begin
            payload_next = payload_in;
        end
    end

    assign match_next = ctl.cmp_en ? (ctl.live && (key_reg == key_in)) : match_reg;

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign key_out     = key_reg;
    assign payload_out = payload_reg;
    assign match       = match_reg;

endmodule

/* hdl/krt_collect.sv */
// ----------------------------------------------------------------------------
// krt_collect
// Resolves the registered match flags of all cells: hit, slot index and the
// record of the matching slot. Keys are unique, so at most one flag is set.
// ----------------------------------------------------------------------------
module krt_collect #(
    parameter int CAPACITY = krt_pkg::CAPACITY_DEF,
    parameter int KW       = krt_pkg::KEY_BITS_DEF,
    parameter int POS_W    = $clog2(CAPACITY)
) (
    input  logic [CAPACITY-1:0]           match,
    input  logic [KW-1:0]                 keys     [CAPACITY],
    input  logic [krt_pkg::PAYLOAD_W-1:0] payloads [CAPACITY],
    output logic                          hit,
    output logic [POS_W-1:0]              pos,
    output logic [KW-1:0]                 sel_key,
    output logic [krt_pkg::PAYLOAD_W-1:0] sel_payload
);

    always_comb
    begin
        pos         = '0;
        sel_key     = '0;
        sel_payload = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (match[i])
            begin
                pos         = pos | POS_W'(i);
                sel_key     = sel_key | keys[i];
                sel_payload = sel_payload | payloads[i];
            end
        end
    end

    assign hit = |match;

endmodule

/* hdl/keyed_record_table.sv */
// ----------------------------------------------------------------------------
// keyed_record_table
// Key/payload table kept in insertion order in a row of slot cells.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Each command runs
// through a compare state, in which every slot compares its key against the
// command key, and an execute state, in which the match is resolved and the
// table updated (append at the fill position, payload overwrite, or a shift
// of all later slots toward the freed slot); then done is high for exactly
// one clock with status, found_key, found_payload and entry_count. The next
// start is taken during that done cycle. There is no way to hold a result
// back; the receiver must capture it when done is high.
// entry_count stays valid between commands.
module keyed_record_table #(
    parameter int CAPACITY = krt_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = krt_pkg::KEY_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        func,
    input  logic [krt_pkg::KEY_PORT_W-1:0]    key,
    input  logic [krt_pkg::PAYLOAD_W-1:0]     payload,
    output logic                              done,
    output logic [1:0]                        status,
    output logic [krt_pkg::KEY_PORT_W-1:0]    found_key,
    output logic [krt_pkg::PAYLOAD_W-1:0]     found_payload,
    output logic [$clog2(CAPACITY+1)-1:0]     entry_count
);

    localparam int KW    = (KEY_BITS < krt_pkg::KEY_PORT_W) ? KEY_BITS
                                                             : krt_pkg::KEY_PORT_W;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int POS_W = $clog2(CAPACITY);

    krt_pkg::krt_state_t           state_reg;
    krt_pkg::krt_state_t           state_next;
    krt_pkg::krt_func_t            func_reg;
    logic [KW-1:0]                 key_reg;
    logic [krt_pkg::PAYLOAD_W-1:0] payload_reg;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic                          done_reg;
    logic                          done_next;
    krt_pkg::krt_status_t          status_reg;
    krt_pkg::krt_status_t          status_next;
    logic [KW-1:0]                 fkey_reg;
    logic [KW-1:0]                 fkey_next;
    logic [krt_pkg::PAYLOAD_W-1:0] fpay_reg;
    logic [krt_pkg::PAYLOAD_W-1:0] fpay_next;

    logic                          accept;
    logic                          do_add;
    logic                          do_del;
    logic                          do_mod;
    logic                          is_full;

    logic [CAPACITY-1:0]           match;
    logic [KW-1:0]                 cell_key     [CAPACITY];
    logic [krt_pkg::PAYLOAD_W-1:0] cell_payload [CAPACITY];
    krt_pkg::krt_cell_ctl_t        cell_ctl     [CAPACITY];
    logic                          hit;
    logic [POS_W-1:0]              pos;
    logic [KW-1:0]                 sel_key;
    logic [krt_pkg::PAYLOAD_W-1:0] sel_payload;

    assign accept  = start && (state_reg == krt_pkg::ST_IDLE);
    assign is_full = (count_reg == CNT_W'(CAPACITY));

    // Sequencer: next state, table update enables and result
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        fkey_next   = fkey_reg;
        fpay_next   = fpay_reg;
        do_add      = 1'b0;
        do_del      = 1'b0;
        do_mod      = 1'b0;
        unique case (state_reg)
            krt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = krt_pkg::ST_CMP;
                end
            end
            krt_pkg::ST_CMP:
            begin
                state_next = krt_pkg::ST_EXEC;
            end
            krt_pkg::ST_EXEC:
            begin
                state_next  = krt_pkg::ST_IDLE;
                done_next   = 1'b1;
                status_next = krt_pkg::STS_DONE;
                fkey_next   = '0;
                fpay_next   = '0;
                unique case (func_reg)
                    krt_pkg::FN_ADD:
                    begin
                        if (hit)
                        begin
                            status_next = krt_pkg::STS_MISS;
                        end
                        else if (is_full)
                        begin
                            status_next = krt_pkg::STS_FULL;
                        end
                        else
                        begin
                            do_add     = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    krt_pkg::FN_GET:
                    begin
                        if (hit)
                        begin
                            fkey_next = sel_key;
                            fpay_next = sel_payload;
                        end
                        else
                        begin
                            status_next = krt_pkg::STS_MISS;
                        end
                    end
                    krt_pkg::FN_DEL:
                    begin
                        if (hit)
                        begin
                            do_del     = 1'b1;
                            count_next = count_reg - CNT_W'(1);
                        end
                        else
                        begin
                            status_next = krt_pkg::STS_MISS;
                        end
                    end
                    krt_pkg::FN_MOD:
                    begin
                        if (hit)
                        begin
                            do_mod = 1'b1;
                        end
                        else
                        begin
                            status_next = krt_pkg::STS_MISS;
                        end
                    end
                    default:
                    begin
                        status_next = krt_pkg::STS_MISS;
                    end
                endcase
            end
            default:
            begin
                state_next = krt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= krt_pkg::ST_IDLE;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            status_reg <= krt_pkg::STS_DONE;
            fkey_reg   <= '0;
            fpay_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            fkey_reg   <= fkey_next;
            fpay_reg   <= fpay_next;
        end
    end

    // command capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg    <= krt_pkg::krt_func_t'(func);
            key_reg     <= KW'(key);
            payload_reg <= payload;
        end
    end

    // slot row; on a delete, each slot from the freed one up loads from the one above
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [KW-1:0]                 nbr_key;
        logic [krt_pkg::PAYLOAD_W-1:0] nbr_payload;

        if (i == CAPACITY - 1)
        begin : g_top
            assign nbr_key     = cell_key[i];
            assign nbr_payload = cell_payload[i];
        end
        else
        begin : g_mid
            assign nbr_key     = cell_key[i+1];
            assign nbr_payload = cell_payload[i+1];
        end

        always_comb
        begin
            cell_ctl[i].cmp_en       = (state_reg == krt_pkg::ST_CMP);
            cell_ctl[i].live         = (CNT_W'(i) < count_reg);
            cell_ctl[i].load_new     = do_add && (count_reg == CNT_W'(i));
            cell_ctl[i].shift        = do_del && (POS_W'(i) >= pos);
            cell_ctl[i].load_payload = do_mod && match[i];
        end

        krt_cell #(
            .KW (KW)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (cell_ctl[i]),
            .key_in      (key_reg),
            .payload_in  (payload_reg),
            .nbr_key     (nbr_key),
            .nbr_payload (nbr_payload),
            .key_out     (cell_key[i]),
            .payload_out (cell_payload[i]),
            .match       (match[i])
        );
    end

    krt_collect #(
        .CAPACITY (CAPACITY),
        .KW       (KW),
        .POS_W    (POS_W)
    ) u_collect (
        .match       (match),
        .keys        (cell_key),
        .payloads    (cell_payload),
        .hit         (hit),
        .pos         (pos),
        .sel_key     (sel_key),
        .sel_payload (sel_payload)
    );

    assign busy          = (state_reg != krt_pkg::ST_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign found_key     = krt_pkg::KEY_PORT_W'(fkey_reg);
    assign found_payload = fpay_reg;
    assign entry_count   = count_reg;

    // keys are unique, so a compare never hits two slots
    a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match))
        else $error("more than one slot matched");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_done_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == krt_pkg::ST_EXEC))
        else $error("done without an executed command");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status_reg == krt_pkg::STS_FULL) |-> is_full)
        else $error("full status with room left");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !done_next |=> $stable(count_reg))
        else $error("entry count changed outside a command");

endmodule
